>>> hdl/ansi_terminal_escape_parser_defines.svh
// Assertion macros for the escape parser checker.
// Each expects clk and arst_n in the scope where it is used.
`ifndef ANSI_TERMINAL_ESCAPE_PARSER_DEFINES_SVH
`define ANSI_TERMINAL_ESCAPE_PARSER_DEFINES_SVH

// same-cycle implication
`define AEP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape parser check failed");

// next-cycle implication
`define AEP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape parser check failed");

`endif

>>> hdl/aep_pkg.sv
package aep_pkg;

	// result command codes
	localparam logic [1:0] CMD_GLYPH  = 2'd0;
	localparam logic [1:0] CMD_FILL   = 2'd1;
	localparam logic [1:0] CMD_SCROLL = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// configuration register indexes
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	// stream bytes
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_QMARK  = 8'h3f;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_B   = 8'h42;
	localparam logic [7:0] CH_UP_C   = 8'h43;
	localparam logic [7:0] CH_UP_D   = 8'h44;
	localparam logic [7:0] CH_UP_G   = 8'h47;
	localparam logic [7:0] CH_UP_H   = 8'h48;
	localparam logic [7:0] CH_UP_J   = 8'h4a;
	localparam logic [7:0] CH_UP_K   = 8'h4b;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_LO_D   = 8'h64;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_H   = 8'h68;
	localparam logic [7:0] CH_LO_L   = 8'h6c;
	localparam logic [7:0] CH_LO_M   = 8'h6d;
	localparam logic [7:0] CH_LO_S   = 8'h73;
	localparam logic [7:0] CH_LO_U   = 8'h75;

	localparam logic [15:0] ACC_MAX   = 16'hffff;
	localparam logic [15:0] ALT_SCRN  = 16'd1049;
	localparam logic [15:0] SGR_FG_EXT = 16'd38;
	localparam logic [15:0] SGR_BG_EXT = 16'd48;
	localparam logic [15:0] EXT_INDEX = 16'd5;
	localparam logic [15:0] EXT_RGB   = 16'd2;
	localparam logic [23:0] RGB_WHITE = 24'hffffff;

	typedef enum logic [4:0] {
		BC_OTHER, BC_ESC, BC_CR, BC_LF, BC_TAB, BC_BEL, BC_BSLASH, BC_LBRACK,
		BC_RBRACK, BC_QMARK, BC_SEMI, BC_SEVEN, BC_EIGHT, BC_FIN_J, BC_FIN_K,
		BC_FIN_M, BC_FIN_HL
	} byte_class_t;

	typedef enum logic [4:0] {
		DOP_IDLE, DOP_CAPTURE, DOP_CR, DOP_NL, DOP_SAVE, DOP_RESTORE, DOP_DIGIT,
		DOP_PUSH, DOP_CLR_ACC, DOP_ARG0, DOP_FINAL, DOP_EMIT_GLYPH, DOP_EMIT_TAB,
		DOP_EMIT_SCROLL, DOP_EMIT_CLEAR, DOP_EMIT_ERASE, DOP_SGR_RESET,
		DOP_SGR_SIMPLE, DOP_SGR_HOLD, DOP_SGR_VAL, DOP_SGR_G, DOP_SGR_B,
		DOP_SGR_PAL, DOP_SGR_RGB
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   have;   // operand present / digit seen / second argument present
		logic   last;   // last result of this byte
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		byte_class_t cls;
		logic        digit;
		logic        wrap;
		logic        nl_scroll;
		logic        out_free;
		logic        rd_ext;
		logic        rd_mode5;
		logic        rd_mode2;
		logic        rd_1049;
	} dp_stat_t;

	// 16 base colours
	function automatic logic [23:0] base_colour(input logic [3:0] idx);
		logic [23:0] c;
		case (idx)
			4'd0:    c = 24'h000000;
			4'd1:    c = 24'haa0000;
			4'd2:    c = 24'h00aa00;
			4'd3:    c = 24'haaaa00;
			4'd4:    c = 24'h0000aa;
			4'd5:    c = 24'haa00aa;
			4'd6:    c = 24'h00aaaa;
			4'd7:    c = 24'haaaaaa;
			4'd8:    c = 24'h555555;
			4'd9:    c = 24'hff5555;
			4'd10:   c = 24'h55ff55;
			4'd11:   c = 24'hffff55;
			4'd12:   c = 24'h5555ff;
			4'd13:   c = 24'hff55ff;
			4'd14:   c = 24'h55ffff;
			default: c = 24'hffffff;
		endcase
		return c;
	endfunction

	// colour cube level: 0, else 55 + 40 * x
	function automatic logic [7:0] cube_level(input logic [2:0] x);
		logic [7:0] v;
		v = (x == 3'd0) ? 8'd0 : 8'd55 + ({5'd0, x} << 5) + ({5'd0, x} << 3);
		return v;
	endfunction

	// 256-colour index to rgb
	function automatic logic [23:0] palette_pick(input logic [15:0] v);
		logic [7:0]  c8;
		logic [13:0] p36;
		logic [2:0]  r;
		logic [5:0]  rem;
		logic [10:0] p6;
		logic [2:0]  g;
		logic [2:0]  b;
		logic [7:0]  grey;
		logic [23:0] res;
		c8   = v[7:0] - 8'd16;
		p36  = 14'({6'd0, c8} * 14'd57);
		r    = p36[13:11];
		rem  = 6'(c8 - 8'({5'd0, r} * 8'd36));
		p6   = 11'({5'd0, rem} * 11'd43);
		g    = p6[10:8];
		b    = 3'(rem - 6'({3'd0, g} * 6'd6));
		grey = 8'd8 + 8'((v[7:0] - 8'd232) * 8'd10);
		if (v < 16'd16)
			res = base_colour(v[3:0]);
		else if (v >= 16'd232 && v <= 16'd255)
			res = {grey, grey, grey};
		else if (v <= 16'd231)
			res = {cube_level(r), cube_level(g), cube_level(b)};
		else
			res = base_colour(4'd7);
		return res;
	endfunction

	function automatic logic [7:0] sat8(input logic [15:0] v);
		return (v > 16'd255) ? 8'hff : v[7:0];
	endfunction

endpackage

>>> hdl/aep_dp.sv
module aep_dp import aep_pkg::*; #(
	parameter int PARAM_SLOTS = 16,
	parameter int AW = $clog2(PARAM_SLOTS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic [7:0]     in_byte,
	input  dp_cmd_t        cmd,
	input  logic [AW-1:0]  rd_addr,
	input  logic [AW-1:0]  wr_addr,
	output dp_stat_t       stat,
	input  logic           out_stall,
	output logic           out_valid,
	output logic [1:0]     command,
	output logic [7:0]     cell_row,
	output logic [7:0]     cell_col,
	output logic [7:0]     glyph_code,
	output logic [7:0]     span_cells,
	output logic [23:0]    fg_rgb,
	output logic [23:0]    bg_rgb,
	output logic           last_of_run
);

	logic [7:0]  cols_q, rows_q;
	logic [7:0]  row_q, col_q, saved_row_q, saved_col_q;
	logic [23:0] fg_q, bg_q;
	logic [15:0] acc_q, arg0_q;
	logic [7:0]  byte_q;
	logic [15:0] param_mem [PARAM_SLOTS];
	logic [15:0] rd_data_q;
	logic        ext_fg_q;
	logic [15:0] ext_val_q;
	logic [7:0]  ext_g_q, ext_b_q;
	logic        out_valid_q;
	logic [1:0]  out_cmd_q;
	logic [7:0]  out_row_q, out_col_q, out_glyph_q, out_span_q;
	logic [23:0] out_fg_q, out_bg_q;
	logic        out_last_q;

	logic [7:0]  cols_eff, rows_eff, cols_last, rows_last;
	byte_class_t cls_c;
	logic [19:0] acc_mul;
	logic [15:0] acc_next;
	logic [8:0]  tab_sum, tab_next;
	logic [7:0]  tab_stop, erase_span;
	logic [15:0] arg1, n_m1, a1_m1;
	logic [16:0] row_up, col_up;
	logic [7:0]  fin_row, fin_col;
	logic [15:0] p, pm30, pm40, pm82, pm92;
	logic [23:0] sg_fg, sg_bg;
	logic        emit;

	assign cols_eff  = (cols_q == 8'd0) ? 8'd1 : cols_q;
	assign rows_eff  = (rows_q == 8'd0) ? 8'd1 : rows_q;
	assign cols_last = cols_eff - 8'd1;
	assign rows_last = rows_eff - 8'd1;

	// byte classification
	always_comb begin
		case (byte_q)
			CH_ESC:    cls_c = BC_ESC;
			CH_CR:     cls_c = BC_CR;
			CH_LF:     cls_c = BC_LF;
			CH_TAB:    cls_c = BC_TAB;
			CH_BEL:    cls_c = BC_BEL;
			CH_BSLASH: cls_c = BC_BSLASH;
			CH_LBRACK: cls_c = BC_LBRACK;
			CH_RBRACK: cls_c = BC_RBRACK;
			CH_QMARK:  cls_c = BC_QMARK;
			CH_SEMI:   cls_c = BC_SEMI;
			CH_SEVEN:  cls_c = BC_SEVEN;
			CH_EIGHT:  cls_c = BC_EIGHT;
			CH_UP_J:   cls_c = BC_FIN_J;
			CH_UP_K:   cls_c = BC_FIN_K;
			CH_LO_M:   cls_c = BC_FIN_M;
			CH_LO_H:   cls_c = BC_FIN_HL;
			CH_LO_L:   cls_c = BC_FIN_HL;
			default:   cls_c = BC_OTHER;
		endcase
	end

	// status flags
	assign stat.cls        = cls_c;
	assign emit            = (cmd.op == DOP_EMIT_GLYPH) || (cmd.op == DOP_EMIT_TAB) ||
	                         (cmd.op == DOP_EMIT_SCROLL) || (cmd.op == DOP_EMIT_CLEAR) ||
	                         (cmd.op == DOP_EMIT_ERASE);
	assign stat.digit      = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
	assign stat.wrap       = (col_q >= cols_eff);
	assign stat.nl_scroll  = !(({1'b0, row_q} + 9'd1) < {1'b0, rows_eff}) &&
	                         (rows_eff >= 8'd2);
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.rd_ext     = (rd_data_q == SGR_FG_EXT) || (rd_data_q == SGR_BG_EXT);
	assign stat.rd_mode5   = (rd_data_q == EXT_INDEX);
	assign stat.rd_mode2   = (rd_data_q == EXT_RGB);
	assign stat.rd_1049    = (rd_data_q == ALT_SCRN);

	// digit accumulate, saturating
	assign acc_mul  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {16'd0, byte_q[3:0]};
	assign acc_next = (acc_mul > {4'd0, ACC_MAX}) ? ACC_MAX : acc_mul[15:0];

	// tab stop and erase span
	assign tab_sum    = {1'b0, col_q} + 9'd8;
	assign tab_next   = tab_sum & ~9'd7;
	assign tab_stop   = (tab_next > {1'b0, cols_eff}) ? cols_eff : tab_next[7:0];
	assign erase_span = (col_q < cols_eff) ? cols_eff - col_q : 8'd0;

	// cursor moves of a CSI final
	always_comb begin
		arg1    = (cmd.have && rd_data_q != 16'd0) ? rd_data_q : 16'd1;
		n_m1    = arg0_q - 16'd1;
		a1_m1   = arg1 - 16'd1;
		row_up  = {9'd0, row_q} + {1'b0, arg0_q};
		col_up  = {9'd0, col_q} + {1'b0, arg0_q};
		fin_row = row_q;
		fin_col = col_q;
		case (byte_q)
			CH_UP_A: fin_row = ({8'd0, row_q} > arg0_q) ? row_q - arg0_q[7:0] : 8'd0;
			CH_UP_B: fin_row = (row_up > {9'd0, rows_last}) ? rows_last : row_up[7:0];
			CH_UP_C: fin_col = (col_up > {9'd0, cols_last}) ? cols_last : col_up[7:0];
			CH_UP_D: fin_col = ({8'd0, col_q} > arg0_q) ? col_q - arg0_q[7:0] : 8'd0;
			CH_UP_G: fin_col = (n_m1 > {8'd0, cols_last}) ? cols_last : n_m1[7:0];
			CH_LO_D: fin_row = (n_m1 > {8'd0, rows_last}) ? rows_last : n_m1[7:0];
			CH_UP_H, CH_LO_F: begin
				fin_row = (n_m1 >= {8'd0, rows_eff}) ? rows_last : n_m1[7:0];
				fin_col = (a1_m1 >= {8'd0, cols_eff}) ? cols_last : a1_m1[7:0];
			end
			CH_LO_U: begin
				fin_row = saved_row_q;
				fin_col = saved_col_q;
			end
			default: ;
		endcase
	end

	// plain SGR codes
	always_comb begin
		p     = rd_data_q;
		pm30  = p - 16'd30;
		pm40  = p - 16'd40;
		pm82  = p - 16'd82;
		pm92  = p - 16'd92;
		sg_fg = fg_q;
		sg_bg = bg_q;
		if (p == 16'd0) begin
			sg_fg = base_colour(4'd7);
			sg_bg = base_colour(4'd0);
		end else if (p >= 16'd30 && p <= 16'd37) begin
			sg_fg = base_colour(pm30[3:0]);
		end else if (p >= 16'd40 && p <= 16'd47) begin
			sg_bg = base_colour(pm40[3:0]);
		end else if (p >= 16'd90 && p <= 16'd97) begin
			sg_fg = base_colour(pm82[3:0]);
		end else if (p >= 16'd100 && p <= 16'd107) begin
			sg_bg = base_colour(pm92[3:0]);
		end else if (p == 16'd39) begin
			sg_fg = base_colour(4'd7);
		end else if (p == 16'd49) begin
			sg_bg = base_colour(4'd0);
		end
	end

	// parameter store, registered read
	always_ff @(posedge clk) begin
		if (cmd.op == DOP_PUSH)
			param_mem[wr_addr] <= cmd.have ? acc_q : 16'd0;
		rd_data_q <= param_mem[rd_addr];
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= 8'd80;
			rows_q      <= 8'd25;
			row_q       <= 8'd0;
			col_q       <= 8'd0;
			saved_row_q <= 8'd0;
			saved_col_q <= 8'd0;
			fg_q        <= RGB_WHITE;
			bg_q        <= 24'd0;
			acc_q       <= 16'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COLS: cols_q <= cfg_data;
					REG_ROWS: rows_q <= cfg_data;
					default:  ;
				endcase
			end
			case (cmd.op)
				DOP_CR: col_q <= 8'd0;
				DOP_NL: begin
					col_q <= 8'd0;
					row_q <= (({1'b0, row_q} + 9'd1) < {1'b0, rows_eff}) ?
					         row_q + 8'd1 : 8'd0;
				end
				DOP_SAVE: begin
					saved_row_q <= row_q;
					saved_col_q <= col_q;
				end
				DOP_RESTORE: begin
					row_q <= saved_row_q;
					col_q <= saved_col_q;
				end
				DOP_DIGIT:   acc_q <= acc_next;
				DOP_PUSH:    acc_q <= 16'd0;
				DOP_CLR_ACC: acc_q <= 16'd0;
				DOP_FINAL: begin
					row_q <= fin_row;
					col_q <= fin_col;
					if (byte_q == CH_LO_S) begin
						saved_row_q <= row_q;
						saved_col_q <= col_q;
					end
				end
				DOP_EMIT_GLYPH:  col_q <= col_q + 8'd1;
				DOP_EMIT_TAB:    col_q <= tab_stop;
				DOP_EMIT_SCROLL: begin
					row_q <= rows_last;
					col_q <= 8'd0;
				end
				DOP_EMIT_CLEAR: begin
					row_q <= 8'd0;
					col_q <= 8'd0;
				end
				DOP_SGR_RESET: begin
					fg_q <= base_colour(4'd7);
					bg_q <= base_colour(4'd0);
				end
				DOP_SGR_SIMPLE: begin
					fg_q <= sg_fg;
					bg_q <= sg_bg;
				end
				DOP_SGR_PAL: begin
					if (ext_fg_q)
						fg_q <= palette_pick(ext_val_q);
					else
						bg_q <= palette_pick(ext_val_q);
				end
				DOP_SGR_RGB: begin
					if (ext_fg_q)
						fg_q <= {sat8(ext_val_q), ext_g_q, ext_b_q};
					else
						bg_q <= {sat8(ext_val_q), ext_g_q, ext_b_q};
				end
				default: ;
			endcase
		end
	end

	// operand holding registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DOP_CAPTURE:  byte_q    <= in_byte;
			DOP_ARG0:     arg0_q    <= (cmd.have && rd_data_q != 16'd0) ? rd_data_q : 16'd1;
			DOP_SGR_HOLD: ext_fg_q  <= (rd_data_q == SGR_FG_EXT);
			DOP_SGR_VAL:  ext_val_q <= cmd.have ? rd_data_q : 16'd7;
			DOP_SGR_G:    ext_g_q   <= cmd.have ? sat8(rd_data_q) : 8'd0;
			DOP_SGR_B:    ext_b_q   <= cmd.have ? sat8(rd_data_q) : 8'd0;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_fg_q    <= fg_q;
			out_bg_q    <= bg_q;
			out_last_q  <= cmd.last;
			out_row_q   <= 8'd0;
			out_col_q   <= 8'd0;
			out_glyph_q <= 8'd0;
			out_span_q  <= 8'd0;
			case (cmd.op)
				DOP_EMIT_GLYPH: begin
					out_cmd_q   <= CMD_GLYPH;
					out_row_q   <= row_q;
					out_col_q   <= col_q;
					out_glyph_q <= byte_q;
				end
				DOP_EMIT_TAB: begin
					out_cmd_q  <= CMD_FILL;
					out_row_q  <= row_q;
					out_col_q  <= col_q;
					out_span_q <= tab_stop - col_q;
				end
				DOP_EMIT_ERASE: begin
					out_cmd_q  <= CMD_FILL;
					out_row_q  <= row_q;
					out_col_q  <= col_q;
					out_span_q <= erase_span;
				end
				DOP_EMIT_SCROLL: out_cmd_q <= CMD_SCROLL;
				default:         out_cmd_q <= CMD_CLEAR;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign command     = out_cmd_q;
	assign cell_row    = out_row_q;
	assign cell_col    = out_col_q;
	assign glyph_code  = out_glyph_q;
	assign span_cells  = out_span_q;
	assign fg_rgb      = out_fg_q;
	assign bg_rgb      = out_bg_q;
	assign last_of_run = out_last_q;

endmodule

>>> hdl/aep_ctrl.sv
module aep_ctrl import aep_pkg::*; #(
	parameter int PARAM_SLOTS = 16,
	parameter int AW = $clog2(PARAM_SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dp_stat_t      stat,
	output dp_cmd_t       cmd,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr
);

	localparam int IW = $clog2(PARAM_SLOTS + 6);

	typedef enum logic [1:0] {MODE_TEXT, MODE_ESC, MODE_CSI, MODE_OSC} parse_mode_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_PUT, S_EMIT, S_FIN0, S_FIN1, S_FIN2, S_SGR_RD,
		S_SGR_P, S_SGR_M, S_SGR_V, S_SGR_G, S_SGR_B, S_SGR_APPLY
	} state_t;

	state_t      state_q, state_nx;
	parse_mode_t mode_q, mode_nx;
	logic        priv_q, priv_nx;
	logic        digit_q, digit_nx;
	logic [IW-1:0] total_q, total_nx;
	logic [IW-1:0] idx_q, idx_nx;
	dp_op_t      pend_op_q, pend_op_nx;
	logic        pend_last_q, pend_last_nx;
	logic        ret_put_q, ret_put_nx;
	logic        ext2_q, ext2_nx;
	logic        alt_q, alt_nx;
	logic [IW-1:0] idx_p1, idx_p2, idx_p3, idx_p4;
	logic        slot_free;

	assign idx_p1    = idx_q + IW'(1);
	assign idx_p2    = idx_q + IW'(2);
	assign idx_p3    = idx_q + IW'(3);
	assign idx_p4    = idx_q + IW'(4);
	assign slot_free = total_q < IW'(PARAM_SLOTS);
	assign in_stall  = (state_q != S_IDLE);
	assign wr_addr   = total_q[AW-1:0];

	// next state and datapath commands
	always_comb begin
		state_nx     = state_q;
		mode_nx      = mode_q;
		priv_nx      = priv_q;
		digit_nx     = digit_q;
		total_nx     = total_q;
		idx_nx       = idx_q;
		pend_op_nx   = pend_op_q;
		pend_last_nx = pend_last_q;
		ret_put_nx   = ret_put_q;
		ext2_nx      = ext2_q;
		alt_nx       = alt_q;
		cmd.op       = DOP_IDLE;
		cmd.have     = 1'b0;
		cmd.last     = 1'b0;
		rd_addr      = idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op   = DOP_CAPTURE;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nx = S_IDLE;
				case (mode_q)
					MODE_ESC: begin
						mode_nx = MODE_TEXT;
						if (stat.cls == BC_LBRACK) begin
							mode_nx  = MODE_CSI;
							total_nx = '0;
							digit_nx = 1'b0;
						end else if (stat.cls == BC_RBRACK) begin
							mode_nx = MODE_OSC;
						end else if (stat.cls == BC_SEVEN) begin
							cmd.op = DOP_SAVE;
						end else if (stat.cls == BC_EIGHT) begin
							cmd.op = DOP_RESTORE;
						end
					end
					MODE_OSC: begin
						if (stat.cls == BC_BEL || stat.cls == BC_BSLASH)
							mode_nx = MODE_TEXT;
					end
					MODE_CSI: begin
						if (stat.cls == BC_QMARK) begin
							priv_nx = 1'b1;
						end else if (stat.digit) begin
							cmd.op   = DOP_DIGIT;
							digit_nx = 1'b1;
						end else if (stat.cls == BC_SEMI) begin
							digit_nx = 1'b0;
							cmd.have = digit_q;
							if (slot_free) begin
								cmd.op   = DOP_PUSH;
								total_nx = total_q + IW'(1);
							end else begin
								cmd.op = DOP_CLR_ACC;
							end
						end else begin
							// final byte: close the open parameter
							cmd.have = digit_q;
							if (slot_free && (digit_q || total_q == '0)) begin
								cmd.op   = DOP_PUSH;
								total_nx = total_q + IW'(1);
							end else begin
								cmd.op = DOP_CLR_ACC;
							end
							state_nx = S_FIN0;
						end
					end
					default: begin
						if (stat.cls == BC_ESC) begin
							mode_nx = MODE_ESC;
						end else if (stat.cls == BC_CR) begin
							cmd.op = DOP_CR;
						end else if (stat.cls == BC_LF) begin
							if (stat.nl_scroll) begin
								pend_op_nx   = DOP_EMIT_SCROLL;
								pend_last_nx = 1'b1;
								ret_put_nx   = 1'b0;
								state_nx     = S_EMIT;
							end else begin
								cmd.op = DOP_NL;
							end
						end else if (stat.wrap) begin
							if (stat.nl_scroll) begin
								pend_op_nx   = DOP_EMIT_SCROLL;
								pend_last_nx = 1'b0;
								ret_put_nx   = 1'b1;
								state_nx     = S_EMIT;
							end else begin
								cmd.op   = DOP_NL;
								state_nx = S_PUT;
							end
						end else begin
							state_nx = S_PUT;
						end
					end
				endcase
			end
			S_PUT: begin
				pend_op_nx   = (stat.cls == BC_TAB) ? DOP_EMIT_TAB : DOP_EMIT_GLYPH;
				pend_last_nx = 1'b1;
				ret_put_nx   = 1'b0;
				state_nx     = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.op   = pend_op_q;
					cmd.last = pend_last_q;
					state_nx = ret_put_q ? S_PUT : S_IDLE;
				end
			end
			S_FIN0: begin
				rd_addr  = '0;
				state_nx = S_FIN1;
			end
			S_FIN1: begin
				cmd.op   = DOP_ARG0;
				cmd.have = (total_q != '0);
				alt_nx   = stat.rd_1049 && (total_q != '0);
				rd_addr  = AW'(1);
				state_nx = S_FIN2;
			end
			S_FIN2: begin
				mode_nx      = MODE_TEXT;
				priv_nx      = 1'b0;
				digit_nx     = 1'b0;
				total_nx     = '0;
				pend_last_nx = 1'b1;
				ret_put_nx   = 1'b0;
				state_nx     = S_IDLE;
				case (stat.cls)
					BC_FIN_J: begin
						pend_op_nx = DOP_EMIT_CLEAR;
						state_nx   = S_EMIT;
					end
					BC_FIN_K: begin
						pend_op_nx = DOP_EMIT_ERASE;
						state_nx   = S_EMIT;
					end
					BC_FIN_M: begin
						if (total_q == '0) begin
							cmd.op = DOP_SGR_RESET;
						end else begin
							total_nx = total_q;
							idx_nx   = '0;
							state_nx = S_SGR_RD;
						end
					end
					BC_FIN_HL: begin
						if (priv_q && alt_q) begin
							pend_op_nx = DOP_EMIT_CLEAR;
							state_nx   = S_EMIT;
						end
					end
					default: begin
						cmd.op   = DOP_FINAL;
						cmd.have = (total_q > IW'(1));
					end
				endcase
			end
			// colour walk, one stored parameter per read
			S_SGR_RD: begin
				if (idx_q < total_q) begin
					state_nx = S_SGR_P;
				end else begin
					total_nx = '0;
					state_nx = S_IDLE;
				end
			end
			S_SGR_P: begin
				if (stat.rd_ext) begin
					cmd.op = DOP_SGR_HOLD;
					if (idx_p1 < total_q) begin
						rd_addr  = idx_p1[AW-1:0];
						state_nx = S_SGR_M;
					end else begin
						idx_nx   = idx_p1;
						state_nx = S_SGR_RD;
					end
				end else begin
					cmd.op   = DOP_SGR_SIMPLE;
					idx_nx   = idx_p1;
					state_nx = S_SGR_RD;
				end
			end
			S_SGR_M: begin
				if (stat.rd_mode5 || stat.rd_mode2) begin
					ext2_nx  = stat.rd_mode2;
					rd_addr  = idx_p2[AW-1:0];
					state_nx = S_SGR_V;
				end else begin
					idx_nx   = idx_p1;
					state_nx = S_SGR_RD;
				end
			end
			S_SGR_V: begin
				cmd.op   = DOP_SGR_VAL;
				cmd.have = (idx_p2 < total_q);
				rd_addr  = idx_p3[AW-1:0];
				state_nx = ext2_q ? S_SGR_G : S_SGR_APPLY;
			end
			S_SGR_G: begin
				cmd.op   = DOP_SGR_G;
				cmd.have = (idx_p3 < total_q);
				rd_addr  = idx_p4[AW-1:0];
				state_nx = S_SGR_B;
			end
			S_SGR_B: begin
				cmd.op   = DOP_SGR_B;
				cmd.have = (idx_p4 < total_q);
				state_nx = S_SGR_APPLY;
			end
			S_SGR_APPLY: begin
				cmd.op   = ext2_q ? DOP_SGR_RGB : DOP_SGR_PAL;
				idx_nx   = ext2_q ? idx_q + IW'(5) : idx_p3;
				state_nx = S_SGR_RD;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_TEXT;
			priv_q      <= 1'b0;
			digit_q     <= 1'b0;
			total_q     <= '0;
			idx_q       <= '0;
			pend_op_q   <= DOP_IDLE;
			pend_last_q <= 1'b0;
			ret_put_q   <= 1'b0;
			ext2_q      <= 1'b0;
			alt_q       <= 1'b0;
		end else begin
			state_q     <= state_nx;
			mode_q      <= mode_nx;
			priv_q      <= priv_nx;
			digit_q     <= digit_nx;
			total_q     <= total_nx;
			idx_q       <= idx_nx;
			pend_op_q   <= pend_op_nx;
			pend_last_q <= pend_last_nx;
			ret_put_q   <= ret_put_nx;
			ext2_q      <= ext2_nx;
			alt_q       <= alt_nx;
		end
	end

endmodule

>>> hdl/ansi_terminal_escape_parser.sv
// Channel   Direction  Handshake              Payload
// config    in         cfg_we                 cfg_index, cfg_data
// text      in         in_valid / in_stall    text_byte
// draw      out        out_valid / out_stall  command .. last_of_run
//
// Each byte is captured and then decoded. A glyph or tab then passes the put
// and emit states (a wrap that scrolls emits the scroll first), a newline
// that scrolls passes the emit state, and a CSI final passes the finishing
// states and then the emit state when the final draws. An SGR then walks its
// parameters over the single read port of the store. Reset is asynchronous
// and needs no clearing pass. A stalled draw beat holds the controller in its
// emit state; text bytes keep flowing while the last beat waits.
module ansi_terminal_escape_parser import aep_pkg::*; #(
	parameter int PARAM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  command,
	output logic [7:0]  cell_row,
	output logic [7:0]  cell_col,
	output logic [7:0]  glyph_code,
	output logic [7:0]  span_cells,
	output logic [23:0] fg_rgb,
	output logic [23:0] bg_rgb,
	output logic        last_of_run
);

	localparam int AW = $clog2(PARAM_SLOTS);

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [AW-1:0] rd_addr, wr_addr;

	// sequencer
	aep_ctrl #(.PARAM_SLOTS(PARAM_SLOTS), .AW(AW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	// cursor, colours, parameters and output beat
	aep_dp #(.PARAM_SLOTS(PARAM_SLOTS), .AW(AW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_byte     (text_byte),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.command     (command),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.glyph_code  (glyph_code),
		.span_cells  (span_cells),
		.fg_rgb      (fg_rgb),
		.bg_rgb      (bg_rgb),
		.last_of_run (last_of_run)
	);

endmodule

>>> hdl/aep_checker.sv
`include "ansi_terminal_escape_parser_defines.svh"

module aep_checker import aep_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  command,
	input logic [7:0]  cell_row,
	input logic [7:0]  cell_col,
	input logic [7:0]  glyph_code,
	input logic [7:0]  span_cells,
	input logic [23:0] fg_rgb,
	input logic [23:0] bg_rgb,
	input logic        last_of_run
);

	// one byte at a time: busy right after a text beat
	`AEP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a glyph always closes its byte's run
	`AEP_ASSERT_NOW(a_glyph_last, out_valid && command == CMD_GLYPH, last_of_run)

	// scroll and clear carry no position
	`AEP_ASSERT_NOW(a_blank_scroll_clear, out_valid && (command == CMD_SCROLL || command == CMD_CLEAR), cell_row == 8'd0 && cell_col == 8'd0 && span_cells == 8'd0 && glyph_code == 8'd0)

	// stalled draw beat holds
	`AEP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(command) && $stable(cell_row) && $stable(cell_col) && $stable(glyph_code) && $stable(span_cells) && $stable(fg_rgb) && $stable(bg_rgb) && $stable(last_of_run))

endmodule

bind ansi_terminal_escape_parser aep_checker u_aep_checker (.*);

>>> tb/ansi_terminal_escape_parser_test.sv
`timescale 1ns / 100ps

module ansi_terminal_escape_parser_test;
	import aep_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic [1:0]  command;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [7:0]  glyph;
		logic [7:0]  span;
		logic [23:0] fg;
		logic [23:0] bg;
		logic        last;
	} draw_t;

	// 16 base colours of the console
	localparam logic [23:0] BASE_RGB [16] = '{
		24'h000000, 24'haa0000, 24'h00aa00, 24'haaaa00,
		24'h0000aa, 24'haa00aa, 24'h00aaaa, 24'haaaaaa,
		24'h555555, 24'hff5555, 24'h55ff55, 24'hffff55,
		24'h5555ff, 24'hff55ff, 24'h55ffff, 24'hffffff};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_COLS;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  command;
	logic [7:0]  cell_row, cell_col, glyph_code, span_cells;
	logic [23:0] fg_rgb, bg_rgb;
	logic        last_of_run;

	ansi_terminal_escape_parser dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// pending text and expected draw beats
	logic [7:0] text_q[$];
	draw_t      draw_q[$];
	int         fail_count = 0;
	bit         quiet = 1'b0;
	int         dead_cycles = 0;

	// console model state
	int          scr_cols = 80, scr_rows = 25;
	int          cur_row = 0, cur_col = 0, mark_row = 0, mark_col = 0;
	logic [23:0] ink = 24'hffffff, paper = 24'h000000;
	int          params[16];
	int          param_cnt = 0, accum = 0;
	bit          have_digit = 0, private_mark = 0;
	int          mode = 0; // 0 text, 1 escape, 2 CSI, 3 OSC
	int          beats_now;

	function automatic int eff_cols();
		return scr_cols ? scr_cols : 1;
	endfunction

	function automatic int eff_rows();
		return scr_rows ? scr_rows : 1;
	endfunction

	function automatic void push_draw(int cmd, int row, int col, int g, int span);
		draw_t d;
		if (beats_now >= 2)
			return;
		d.command = cmd[1:0];
		d.row = row[7:0];
		d.col = col[7:0];
		d.glyph = g[7:0];
		d.span = span[7:0];
		d.fg = ink;
		d.bg = paper;
		d.last = 1'b0;
		draw_q.push_back(d);
		beats_now++;
	endfunction

	function automatic void line_feed();
		cur_col = 0;
		if (cur_row + 1 < eff_rows())
			cur_row++;
		else if (eff_rows() < 2)
			cur_row = 0;
		else begin
			push_draw(CMD_SCROLL, 0, 0, 0, 0);
			cur_row = eff_rows() - 1;
		end
	endfunction

	function automatic void wipe_screen();
		cur_row = 0;
		cur_col = 0;
		push_draw(CMD_CLEAR, 0, 0, 0, 0);
	endfunction

	function automatic logic [23:0] xterm_colour(int v);
		int c, r, g, b;
		if (v < 16)
			return BASE_RGB[v];
		if (v >= 232 && v <= 255) begin
			c = 8 + (v - 232) * 10;
			return {c[7:0], c[7:0], c[7:0]};
		end
		if (v <= 231) begin
			c = v - 16;
			r = c / 36;
			g = (c / 6) % 6;
			b = c % 6;
			r = r ? 55 + r * 40 : 0;
			g = g ? 55 + g * 40 : 0;
			b = b ? 55 + b * 40 : 0;
			return {r[7:0], g[7:0], b[7:0]};
		end
		return BASE_RGB[7];
	endfunction

	function automatic logic [7:0] clip8(int v);
		return v > 255 ? 8'hff : v[7:0];
	endfunction

	function automatic int arg_default(int k, int dflt);
		if (k >= param_cnt || params[k] == 0)
			return dflt;
		return params[k];
	endfunction

	// SGR walk over the stored parameters
	function automatic void set_colours();
		int n, i, p, sel, v, g, b;
		logic [23:0] rgb;
		n = param_cnt ? param_cnt : 1;
		i = 0;
		while (i < n) begin
			p = param_cnt ? params[i] : 0;
			if (p == 0) begin
				ink = BASE_RGB[7];
				paper = BASE_RGB[0];
			end else if (p >= 30 && p <= 37) ink = BASE_RGB[p - 30];
			else if (p >= 40 && p <= 47) paper = BASE_RGB[p - 40];
			else if (p >= 90 && p <= 97) ink = BASE_RGB[p - 82];
			else if (p >= 100 && p <= 107) paper = BASE_RGB[p - 92];
			else if (p == 39) ink = BASE_RGB[7];
			else if (p == 49) paper = BASE_RGB[0];
			else if (p == 38 || p == 48) begin
				sel = i + 1 < n ? params[i + 1] : 0;
				v = i + 2 < n ? params[i + 2] : 7;
				if (sel == 5) begin
					if (p == 38) ink = xterm_colour(v);
					else paper = xterm_colour(v);
					i += 2;
				end else if (sel == 2) begin
					g = i + 3 < n ? params[i + 3] : 0;
					b = i + 4 < n ? params[i + 4] : 0;
					rgb = {clip8(v), clip8(g), clip8(b)};
					if (p == 38) ink = rgb;
					else paper = rgb;
					i += 4;
				end
			end
			i++;
		end
	endfunction

	function automatic void run_final(int fin);
		int n, r, c, rr, cc;
		n = arg_default(0, 1);
		rr = eff_rows();
		cc = eff_cols();
		if (fin == CH_UP_A) cur_row = cur_row > n ? cur_row - n : 0;
		else if (fin == CH_UP_B) cur_row = (cur_row + n > rr - 1) ? rr - 1 : cur_row + n;
		else if (fin == CH_UP_C) cur_col = (cur_col + n > cc - 1) ? cc - 1 : cur_col + n;
		else if (fin == CH_UP_D) cur_col = cur_col > n ? cur_col - n : 0;
		else if (fin == CH_UP_G) cur_col = (n - 1 > cc - 1) ? cc - 1 : n - 1;
		else if (fin == CH_LO_D) cur_row = (n - 1 > rr - 1) ? rr - 1 : n - 1;
		else if (fin == CH_UP_H || fin == CH_LO_F) begin
			r = arg_default(0, 1) - 1;
			c = arg_default(1, 1) - 1;
			cur_row = r >= rr ? rr - 1 : r;
			cur_col = c >= cc ? cc - 1 : c;
		end else if (fin == CH_UP_J) wipe_screen();
		else if (fin == CH_UP_K)
			push_draw(CMD_FILL, cur_row, cur_col, 0, cur_col < cc ? cc - cur_col : 0);
		else if (fin == CH_LO_M) set_colours();
		else if (fin == CH_LO_S) begin
			mark_row = cur_row;
			mark_col = cur_col;
		end else if (fin == CH_LO_U) begin
			cur_row = mark_row;
			cur_col = mark_col;
		end else if (fin == CH_LO_H || fin == CH_LO_L) begin
			if (private_mark && param_cnt && params[0] == int'(ALT_SCRN))
				wipe_screen();
		end
		mode = 0;
		param_cnt = 0;
		accum = 0;
		have_digit = 0;
		private_mark = 0;
	endfunction

	function automatic void print_byte(int ch);
		int nxt;
		if (ch == CH_CR) begin
			cur_col = 0;
			return;
		end
		if (ch == CH_LF) begin
			line_feed();
			return;
		end
		if (cur_col >= eff_cols())
			line_feed();
		if (ch == CH_TAB) begin
			nxt = (cur_col + 8) & ~7;
			if (nxt > eff_cols())
				nxt = eff_cols();
			push_draw(CMD_FILL, cur_row, cur_col, 0, nxt - cur_col);
			cur_col = nxt;
			return;
		end
		push_draw(CMD_GLYPH, cur_row, cur_col, ch, 0);
		cur_col++;
	endfunction

	// expected draw beats for one accepted byte
	function automatic void decode_byte(int ch);
		beats_now = 0;
		if (mode == 1) begin
			if (ch == CH_LBRACK) begin
				mode = 2;
				param_cnt = 0;
				accum = 0;
				have_digit = 0;
			end else if (ch == CH_RBRACK) mode = 3;
			else begin
				if (ch == CH_SEVEN) begin
					mark_row = cur_row;
					mark_col = cur_col;
				end else if (ch == CH_EIGHT) begin
					cur_row = mark_row;
					cur_col = mark_col;
				end
				mode = 0;
			end
		end else if (mode == 3) begin
			if (ch == CH_BEL || ch == CH_BSLASH)
				mode = 0;
		end else if (mode == 2) begin
			if (ch == CH_QMARK) private_mark = 1;
			else if (ch >= CH_ZERO && ch <= CH_NINE) begin
				accum = accum * 10 + (ch - CH_ZERO);
				if (accum > 65535)
					accum = 65535;
				have_digit = 1;
			end else if (ch == CH_SEMI) begin
				if (param_cnt < 16)
					params[param_cnt++] = have_digit ? accum : 0;
				accum = 0;
				have_digit = 0;
			end else begin
				if (param_cnt < 16 && (have_digit || param_cnt == 0))
					params[param_cnt++] = have_digit ? accum : 0;
				run_final(ch);
			end
		end else begin
			if (ch == CH_ESC) mode = 1;
			else print_byte(ch);
		end
		if (beats_now > 0)
			draw_q[$].last = 1'b1;
	endfunction

	// stimulus builders
	function automatic void put_num(int v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic void put_csi(string body, logic [7:0] fin);
		text_q.push_back(CH_ESC);
		text_q.push_back(CH_LBRACK);
		for (int i = 0; i < body.len(); i++)
			text_q.push_back(body[i]);
		text_q.push_back(fin);
	endfunction

	function automatic int rand_param();
		int k;
		k = $urandom_range(99);
		if (k < 8) return 0;
		if (k < 14) return $urandom_range(65535, 1000);
		if (k < 18) return 999999;
		if (k < 60) return $urandom_range(9);
		if (k < 85) return $urandom_range(120);
		return $urandom_range(300);
	endfunction

	function automatic logic [7:0] rand_final();
		logic [7:0] fins[14] = '{CH_UP_A, CH_UP_B, CH_UP_C, CH_UP_D, CH_UP_G, CH_LO_D,
			CH_UP_H, CH_LO_F, CH_UP_J, CH_UP_K, CH_LO_M, CH_LO_S, CH_LO_U, CH_LO_H};
		if ($urandom_range(19) == 0) return CH_LO_L;
		if ($urandom_range(14) == 0) return 8'($urandom_range(255));
		return fins[$urandom_range(13)];
	endfunction

	// one random group of bytes: text, a control sequence or noise
	function automatic void add_group();
		int k, n;
		k = $urandom_range(99);
		if (k < 35) begin
			n = $urandom_range(8, 1);
			repeat (n) begin
				case ($urandom_range(9))
					0: text_q.push_back(CH_LF);
					1: text_q.push_back(CH_CR);
					2: text_q.push_back(CH_TAB);
					3: text_q.push_back(8'($urandom_range(255)));
					default: text_q.push_back(8'($urandom_range(126, 32)));
				endcase
			end
		end else if (k < 60) begin
			text_q.push_back(CH_ESC);
			text_q.push_back(CH_LBRACK);
			if ($urandom_range(7) == 0) text_q.push_back(CH_QMARK);
			n = ($urandom_range(19) == 0) ? $urandom_range(19, 15) : $urandom_range(3);
			for (int i = 0; i < n; i++) begin
				if (i) text_q.push_back(CH_SEMI);
				if ($urandom_range(9)) put_num(rand_param());
			end
			text_q.push_back(rand_final());
		end else if (k < 78) begin
			text_q.push_back(CH_ESC);
			text_q.push_back(CH_LBRACK);
			n = $urandom_range(3, 1);
			for (int i = 0; i < n; i++) begin
				if (i) text_q.push_back(CH_SEMI);
				case ($urandom_range(4))
					0: begin
						put_num($urandom_range(1) ? 38 : 48);
						put_csi_tail_index();
					end
					1: begin
						put_num($urandom_range(1) ? 38 : 48);
						text_q.push_back(CH_SEMI);
						put_num(2);
						repeat ($urandom_range(3)) begin
							text_q.push_back(CH_SEMI);
							put_num($urandom_range(300));
						end
					end
					2: put_num($urandom_range(1) ? $urandom_range(49, 30) : $urandom_range(107, 90));
					3: put_num($urandom_range(2) ? 0 : 39 + 10 * $urandom_range(1));
					default: put_num(rand_param());
				endcase
			end
			text_q.push_back(CH_LO_M);
		end else if (k < 84) begin
			text_q.push_back(CH_ESC);
			text_q.push_back(CH_RBRACK);
			repeat ($urandom_range(6)) text_q.push_back(8'($urandom_range(126, 32)) | 8'h80);
			text_q.push_back($urandom_range(1) ? CH_BEL : CH_BSLASH);
		end else if (k < 92) begin
			text_q.push_back(CH_ESC);
			case ($urandom_range(3))
				0: text_q.push_back(CH_SEVEN);
				1: text_q.push_back(CH_EIGHT);
				default: text_q.push_back(8'($urandom_range(255)));
			endcase
		end else if (k < 95) begin
			put_csi($urandom_range(1) ? "?1049" : "?47", $urandom_range(1) ? CH_LO_H : CH_LO_L);
		end else begin
			repeat ($urandom_range(4, 1)) text_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	function automatic void put_csi_tail_index();
		text_q.push_back(CH_SEMI);
		put_num(5);
		if ($urandom_range(5)) begin
			text_q.push_back(CH_SEMI);
			put_num($urandom_range(3) ? $urandom_range(255) : $urandom_range(400));
		end
	endfunction

	// driver: one byte per beat on the text channel
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				decode_byte(text_byte);
			if (!in_valid || !in_stall) begin
				if (text_q.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
					in_valid <= 1'b1;
					text_byte <= text_q.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s expected %0h got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// monitor: draw beats against the oldest expectation
	always @(posedge clk) begin
		draw_t d;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (draw_q.size() == 0) begin
					$error("unexpected draw beat, command %0d", command);
					fail_count++;
				end else begin
					d = draw_q.pop_front();
					check_field("command", d.command, command);
					check_field("cell_row", d.row, cell_row);
					check_field("cell_col", d.col, cell_col);
					check_field("glyph_code", d.glyph, glyph_code);
					check_field("span_cells", d.span, span_cells);
					check_field("fg_rgb", d.fg, fg_rgb);
					check_field("bg_rgb", d.bg, bg_rgb);
					check_field("last_of_run", d.last, last_of_run);
				end
			end
		end
		out_stall <= !quiet && $urandom_range(99) < 24;
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			dead_cycles <= 0;
		else
			dead_cycles <= dead_cycles + 1;
		if (dead_cycles >= IDLE_LIMIT) begin
			$display("FAIL ansi_terminal_escape_parser");
			$finish;
		end
	end

	task automatic write_geometry(int c, int r);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_COLS;
		cfg_data <= 8'(c);
		@(posedge clk);
		cfg_index <= REG_ROWS;
		cfg_data <= 8'(r);
		@(posedge clk);
		cfg_we <= 1'b0;
		scr_cols = c;
		scr_rows = r;
	endtask

	task automatic drain();
		wait (text_q.size() == 0 && !in_valid && draw_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	int geo_c[6] = '{80, 1, 255, 0, 13, 0};
	int geo_r[6] = '{25, 1, 255, 0, 4, 0};

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, tab stops, wrap, saves, erases and colours
		text_q.push_back(8'h00);
		text_q.push_back(8'hff);
		text_q.push_back(CH_TAB);
		text_q.push_back(CH_CR);
		text_q.push_back(CH_LF);
		text_q.push_back(CH_ESC);
		text_q.push_back(CH_SEVEN);
		put_csi("99;99", CH_UP_H);
		text_q.push_back(CH_TAB);
		text_q.push_back(CH_LO_M);
		put_csi("", CH_UP_K);
		put_csi("38;5;196;48;2;300;7", CH_LO_M);
		put_csi("?1049", CH_LO_H);
		text_q.push_back(CH_ESC);
		text_q.push_back(CH_EIGHT);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				write_geometry($urandom_range(255, 1), $urandom_range(255, 1));
			else
				write_geometry(geo_c[ph], geo_r[ph]);
			quiet = (ph == 2);
			// scroll heavily on the small 13x4 screen, then random groups
			if (ph == 4)
				repeat (10) text_q.push_back(CH_LF);
			while (text_q.size() < 240)
				add_group();
			drain();
		end

		if (fail_count == 0)
			$display("PASS ansi_terminal_escape_parser");
		else
			$display("FAIL ansi_terminal_escape_parser");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/aep_pkg.sv
hdl/aep_dp.sv
hdl/aep_ctrl.sv
hdl/ansi_terminal_escape_parser.sv
hdl/aep_checker.sv
tb/ansi_terminal_escape_parser_test.sv
